// ===== sv/mfc_pkg.sv =====
// Shared types, register indexes and frame helpers for the motor frame codec.
package mfc_pkg;

  localparam int unsigned FrameBits = 16;
  localparam int unsigned ValueW    = 11;
  localparam int unsigned DutyW     = 16;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CntW      = 4;

  localparam logic [ValueW-1:0]  ValueMax     = 11'd2047;
  localparam logic [DutyW-1:0]   DutyOneRst   = 16'd120;
  localparam logic [DutyW-1:0]   DutyZeroRst  = 16'd60;
  localparam logic [CntW-1:0]    LastBitCnt   = 4'hf;

  localparam logic [CfgIdxW-1:0] RegDutyOne  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegDutyZero = 8'd1;

  localparam logic OpTx = 1'b0;
  localparam logic OpRx = 1'b1;

  localparam logic KindTx = 1'b0;
  localparam logic KindRx = 1'b1;

  typedef struct packed {
    logic              done;
    logic [ValueW-1:0] value;
    logic              ok;
  } rx_res_t;

  // Frame layout: value, check bit, then the XOR of the three nibbles above.
  function automatic logic [FrameBits-1:0] make_frame(logic [ValueW-1:0] value,
                                                      logic check);
    logic [11:0] head;
    logic [3:0]  x;
    head = {value, check};
    x    = head[3:0] ^ head[7:4] ^ head[11:8];
    return {head, x};
  endfunction

endpackage

// ===== sv/mfc_rx_deframer.sv =====
// Receive shift register, bit count and frame check for the motor frame codec.
module mfc_rx_deframer
  import mfc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    bit_en_i,
  input  logic    line_bit_i,
  input  logic    clear_i,
  output rx_res_t res_o
);

  logic [FrameBits-1:0] shift_q, shift_d;
  logic [CntW-1:0]      cnt_q, cnt_d;

  always_comb begin
    shift_d = {shift_q[FrameBits-2:0], line_bit_i};
    cnt_d   = cnt_q + 1'b1;
  end

  // The result describes the frame as it stands once the current bit is in.
  always_comb begin
    res_o.done  = (cnt_q == LastBitCnt);
    res_o.value = shift_d[FrameBits-1:5];
    res_o.ok    = (make_frame(shift_d[FrameBits-1:5], 1'b1) == shift_d) && shift_d[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      cnt_q   <= '0;
    end else if (bit_en_i) begin
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
    end else if (clear_i) begin
      cnt_q   <= '0;
    end
  end

endmodule

// ===== sv/motor_frame_codec_xor_nibble_check.sv =====
// Top level of the motor frame codec: input stage, transmit serializer, receive deframer, output register.
//
//   channel | signals                                      | direction
//   --------+----------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, op, tx_value, line   | in
//   out     | out_valid_o, out_stall_i, kind, duty, last,  | out
//           | rx_value, rx_ok                              |
//   cfg     | cfg_valid_i, cfg_ready_o, index, data        | in
//
// A receive word leaves the input stage with its one bit, waiting on the output only when
// it closes a frame; a transmit word holds the stage for all sixteen duty words, so the
// output register sets the transmit rate. Every result is registered in the output register.
// Reset clears the receive state and loads the duty registers with 120 and 60.
// A stall on the output holds the output register and backs up into the input stage.
module motor_frame_codec_xor_nibble_check
  import mfc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_op_i,
  input  logic [15:0]        in_tx_value_i,
  input  logic               in_line_bit_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               out_kind_o,
  output logic [DutyW-1:0]   out_duty_o,
  output logic               out_last_o,
  output logic [ValueW-1:0]  out_rx_value_o,
  output logic               out_rx_ok_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DutyW-1:0]   cfg_data_i
);

  logic [DutyW-1:0] duty_one_q, duty_zero_q;

  logic                 s1_valid_q;
  logic                 s1_op_q;
  logic                 s1_line_q;
  logic [FrameBits-1:0] s1_frame_q, s1_frame_d;
  logic [CntW-1:0]      s1_cnt_q;

  logic                 out_valid_q;
  logic                 out_kind_q;
  logic [DutyW-1:0]     out_duty_q;
  logic                 out_last_q;
  logic [ValueW-1:0]    out_value_q;
  logic                 out_ok_q;

  logic       in_accept;
  logic       out_ready;
  logic       emits;
  logic       fire;
  logic       last_beat;
  logic       s1_free;
  logic [ValueW-1:0] sat_value;
  rx_res_t    rx_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_one_q  <= DutyOneRst;
      duty_zero_q <= DutyZeroRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegDutyOne:  duty_one_q  <= cfg_data_i;
        RegDutyZero: duty_zero_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mfc_rx_deframer u_rx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .bit_en_i   (fire && (s1_op_q == OpRx)),
    .line_bit_i (s1_line_q),
    .clear_i    (fire && (s1_op_q == OpTx)),
    .res_o      (rx_res)
  );

  assign out_ready = !out_valid_q || !out_stall_i;
  // A receive bit that does not close a frame leaves without waiting on the output.
  assign emits     = (s1_op_q == OpTx) || rx_res.done;
  assign fire      = s1_valid_q && (emits ? out_ready : 1'b1);
  assign last_beat = (s1_op_q == OpRx) || (s1_cnt_q == LastBitCnt);
  assign s1_free   = !s1_valid_q || (fire && last_beat);
  assign in_stall_o = !s1_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign sat_value  = (in_tx_value_i > {5'd0, ValueMax}) ? ValueMax : in_tx_value_i[ValueW-1:0];
  assign s1_frame_d = make_frame(sat_value, 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_cnt_q   <= '0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
      s1_cnt_q   <= '0;
    end else if (fire) begin
      s1_valid_q <= !last_beat;
      s1_cnt_q   <= s1_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q    <= in_op_i;
      s1_line_q  <= in_line_bit_i;
      s1_frame_q <= s1_frame_d;
    end else if (fire) begin
      s1_frame_q <= {s1_frame_q[FrameBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= fire && emits;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emits) begin
      if (s1_op_q == OpTx) begin
        out_kind_q  <= KindTx;
        out_duty_q  <= s1_frame_q[FrameBits-1] ? duty_one_q : duty_zero_q;
        out_last_q  <= (s1_cnt_q == LastBitCnt);
        out_value_q <= '0;
        out_ok_q    <= 1'b0;
      end else begin
        out_kind_q  <= KindRx;
        out_duty_q  <= '0;
        out_last_q  <= 1'b0;
        out_value_q <= rx_res.value;
        out_ok_q    <= rx_res.ok;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = out_kind_q;
  assign out_duty_o     = out_duty_q;
  assign out_last_o     = out_last_q;
  assign out_rx_value_o = out_value_q;
  assign out_rx_ok_o    = out_ok_q;

  a_last_only_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> out_kind_q == KindTx)
    else $error("last flag set on a received frame word");

  a_rx_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q == KindRx |-> out_duty_q == '0 && !out_last_q)
    else $error("received frame word carries transmit fields");

  a_tx_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_op_q == OpTx && s1_cnt_q != LastBitCnt |-> in_stall_o)
    else $error("input taken while a transmit run is unfinished");

  a_tx_end_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && s1_op_q == OpTx && s1_cnt_q == LastBitCnt |=> out_valid_q && out_last_q)
    else $error("final transmit word not marked last");

endmodule

// ===== sim/motor_frame_codec_xor_nibble_check_tb.sv =====
// Self-checking testbench for the motor frame codec: a directed table, then random traffic.
module motor_frame_codec_xor_nibble_check_tb;
  import mfc_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned LongHold    = 300;

  typedef struct packed {
    logic              kind;
    logic [DutyW-1:0]  duty;
    logic              last;
    logic [ValueW-1:0] rx_value;
    logic              rx_ok;
  } codec_word_t;

  typedef struct packed {
    logic        op;
    logic [15:0] tx_value;
    logic        line_bit;
    logic [4:0]  reps;
    logic        typed;
    codec_word_t first;
  } plan_row_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic               in_op_i       = OpTx;
  logic [15:0]        in_tx_value_i = '0;
  logic               in_line_bit_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic               out_kind_o;
  logic [DutyW-1:0]   out_duty_o;
  logic               out_last_o;
  logic [ValueW-1:0]  out_rx_value_o;
  logic               out_rx_ok_o;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i   = RegDutyOne;
  logic [DutyW-1:0]   cfg_data_i    = '0;

  // Predicted copy of the block's registers and receive state.
  logic [DutyW-1:0]     duty_one_q  = DutyOneRst;
  logic [DutyW-1:0]     duty_zero_q = DutyZeroRst;
  logic [FrameBits-1:0] rx_shift_q  = '0;
  logic [CntW-1:0]      rx_count_q  = '0;

  codec_word_t pending_words[$];
  int unsigned mismatches   = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned rx_bits_sent = 0;
  int unsigned hold_left    = 0;
  logic        hold_request = 1'b0;
  logic        send_gaps    = 1'b1;
  logic        recv_gaps    = 1'b1;
  logic        cur_typed    = 1'b0;
  codec_word_t cur_want     = '0;

  // Typed rows give the first word they cause; all other words come from the predictor.
  plan_row_t plan [7] = '{
    '{OpTx, 16'h0000, 1'b1, 5'd1,  1'b1, '{KindTx, 16'd60,  1'b0, 11'd0,    1'b0}},
    '{OpTx, 16'hffff, 1'b0, 5'd1,  1'b1, '{KindTx, 16'd120, 1'b0, 11'd0,    1'b0}},
    '{OpTx, 16'h07ff, 1'b1, 5'd1,  1'b0, '0},
    '{OpRx, 16'hffff, 1'b1, 5'd3,  1'b0, '0},
    '{OpTx, 16'h0800, 1'b0, 5'd1,  1'b1, '{KindTx, 16'd120, 1'b0, 11'd0,    1'b0}},
    '{OpRx, 16'ha5a5, 1'b1, 5'd15, 1'b0, '0},
    '{OpRx, 16'h0000, 1'b0, 5'd1,  1'b1, '{KindRx, 16'd0,   1'b0, 11'd2047, 1'b0}}
  };

  motor_frame_codec_xor_nibble_check uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_op_i        (in_op_i),
    .in_tx_value_i  (in_tx_value_i),
    .in_line_bit_i  (in_line_bit_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_kind_o     (out_kind_o),
    .out_duty_o     (out_duty_o),
    .out_last_o     (out_last_o),
    .out_rx_value_o (out_rx_value_o),
    .out_rx_ok_o    (out_rx_ok_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [FrameBits-1:0] frame_of(logic [ValueW-1:0] value,
                                                    logic check_bit);
    logic [11:0] head;
    head = {value, check_bit};
    return {head, head[11:8] ^ head[7:4] ^ head[3:0]};
  endfunction

  function automatic logic [15:0] tx_pick();
    case ($urandom_range(3))
      0: return 16'($urandom_range(2047));
      1: return 16'($urandom_range(2040, 2055));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // A transmit word expands into sixteen duty words; a receive word shifts in one bit
  // and yields a frame word when the sixteenth bit lands.
  task automatic encode_or_collect(input logic op, input logic [15:0] tx_value,
                                   input logic line_bit);
    logic [ValueW-1:0]    value;
    logic [FrameBits-1:0] frame;
    codec_word_t          w;
    int                   i;
    if (op == OpTx) begin
      value      = (tx_value > ValueMax) ? ValueMax : tx_value[ValueW-1:0];
      frame      = frame_of(value, 1'b0);
      rx_count_q = '0;
      for (i = 0; i < FrameBits; i++) begin
        w.kind     = KindTx;
        w.duty     = frame[FrameBits-1-i] ? duty_one_q : duty_zero_q;
        w.last     = (i == FrameBits - 1);
        w.rx_value = '0;
        w.rx_ok    = 1'b0;
        pending_words.push_back(w);
      end
    end else begin
      rx_shift_q = {rx_shift_q[FrameBits-2:0], line_bit};
      rx_count_q = rx_count_q + 1'b1;
      if (rx_count_q == '0) begin
        w.kind     = KindRx;
        w.duty     = '0;
        w.last     = 1'b0;
        w.rx_value = rx_shift_q[15:5];
        w.rx_ok    = (frame_of(w.rx_value, 1'b1) == rx_shift_q) && rx_shift_q[4];
        pending_words.push_back(w);
      end
    end
  endtask

  always @(posedge clk_i) begin : watch
    codec_word_t want;
    int unsigned base;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegDutyOne) begin
          duty_one_q = cfg_data_i;
        end else if (cfg_index_i == RegDutyZero) begin
          duty_zero_q = cfg_data_i;
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected word, kind %0d duty %0d rx_value %0d rx_ok %0d",
                   $time, out_kind_o, out_duty_o, out_rx_value_o, out_rx_ok_o);
          mismatches++;
        end else begin
          want = pending_words.pop_front();
          check_field("kind", want.kind, out_kind_o);
          check_field("duty", want.duty, out_duty_o);
          check_field("last", want.last, out_last_o);
          check_field("rx_value", want.rx_value, out_rx_value_o);
          check_field("rx_ok", want.rx_ok, out_rx_ok_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        base = pending_words.size();
        encode_or_collect(in_op_i, in_tx_value_i, in_line_bit_i);
        if (cur_typed && pending_words.size() > base) begin
          pending_words[base] = cur_want;
        end
      end
    end
  end

  // Output backpressure, with one long hold on request to fill the block up.
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = LongHold;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
    end
    out_stall_i <= (hold_left != 0) || (recv_gaps && $urandom_range(99) < 38);
  end

  // Valid stays high after acceptance until the next word or an idle cycle replaces it.
  task automatic offer_word(input logic op, input logic [15:0] tx_value,
                            input logic line_bit, input logic typed,
                            input codec_word_t first);
    @(negedge clk_i);
    while (send_gaps && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    cur_typed = typed;
    cur_want  = first;
    in_valid_i    <= 1'b1;
    in_op_i       <= op;
    in_tx_value_i <= tx_value;
    in_line_bit_i <= line_bit;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    rx_bits_sent = (op == OpTx) ? 0 : (rx_bits_sent + 1) % FrameBits;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [DutyW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly whole frames sent bit by bit, some corrupted, mixed with transmit words and
  // stray bit bursts that a later transmit word cuts short.
  task automatic random_traffic(input int unsigned count);
    int unsigned          sent;
    int unsigned          pick;
    int unsigned          k;
    logic [FrameBits-1:0] frame;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        if (rx_bits_sent != 0) begin
          offer_word(OpTx, tx_pick(), 1'($urandom_range(1)), 1'b0, '0);
          sent++;
        end
        frame = frame_of(11'($urandom_range(2047)), $urandom_range(9) != 0);
        if ($urandom_range(99) < 15) begin
          k        = $urandom_range(FrameBits - 1);
          frame[k] = ~frame[k];
        end
        for (k = 0; k < FrameBits; k++) begin
          offer_word(OpRx, 16'($urandom), frame[FrameBits-1-k], 1'b0, '0);
          sent++;
        end
      end else if (pick < 82) begin
        offer_word(OpTx, tx_pick(), 1'($urandom_range(1)), 1'b0, '0);
        sent++;
      end else begin
        repeat ($urandom_range(1, 15)) begin
          offer_word(OpRx, 16'($urandom), 1'($urandom_range(1)), 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int unsigned r;
    int unsigned k;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (r = 0; r < $size(plan); r++) begin
      for (k = 0; k < plan[r].reps; k++) begin
        offer_word(plan[r].op, plan[r].tx_value, plan[r].line_bit, plan[r].typed,
                   plan[r].first);
      end
    end
    settle();
    write_reg(RegDutyOne, 16'hffff);
    write_reg(RegDutyZero, 16'h0000);
    random_traffic(70);
    settle();
    write_reg(RegDutyOne, 16'h0000);
    write_reg(RegDutyZero, 16'hffff);
    random_traffic(70);
    settle();
    write_reg(RegDutyOne, 16'($urandom));
    write_reg(RegDutyZero, 16'($urandom));
    hold_request = 1'b1;
    random_traffic(60);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    random_traffic(60);
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    random_traffic(60);
    settle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule
